// ===== hdl/iwn_pkg.sv =====
// Shared types, constants and calendar tables for the ISO week number pipeline.
// Used by every module of the block; depends on nothing.
package iwn_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned WEEK_W  = 6;

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    // year + 399 equals year - 1 modulo 400 and never goes negative.
    localparam logic [14:0] YEAR_OFFSET = 15'd399;
    // floor(2^16 / 25): applied to p / 16 it gives p / 400, low by at most one.
    localparam logic [11:0] RECIP_25    = 12'd2621;
    // ceil(2^11 / 7): exact floor division by 7 for values below 683.
    localparam logic [8:0]  RECIP_7     = 9'd293;

    localparam logic [WEEK_W-1:0] WEEK_LONG  = 6'd53;
    localparam logic [WEEK_W-1:0] WEEK_SHORT = 6'd52;
    localparam logic [WEEK_W-1:0] WEEK_FIRST = 6'd1;

    localparam logic [2:0] MONDAY   = 3'd1;
    localparam logic [2:0] THURSDAY = 3'd4;
    localparam logic [2:0] FRIDAY   = 3'd5;
    localparam logic [2:0] SATURDAY = 3'd6;
    localparam logic [2:0] SUNDAY   = 3'd7;

    // After the date stage.
    typedef struct packed {
        logic [14:0] p;          // year + 399
        logic [5:0]  q_est;      // p / 400, possibly one low
        logic [8:0]  doy_base;   // day of year without the leap day
        logic        bad_base;   // invalid regardless of leap year
        logic        feb29;      // 29 February, valid only in leap years
        logic        after_feb;
    } t_s1;

    // After the year reduction stage.
    typedef struct packed {
        logic [8:0] r400;        // (year - 1) mod 400
        logic       leap;
        logic       prev_leap;
        logic       err;
        logic [8:0] doy;
    } t_s2;

    // After the weekday stage.
    typedef struct packed {
        logic [2:0] j1;          // ISO weekday of 1 January
        logic       leap;
        logic       prev_leap;
        logic       err;
        logic [8:0] doy;
    } t_s3;

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] l;
        case (month)
            4'd2:                  l = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: l = 5'd30;
            default:               l = 5'd31;
        endcase
        return l;
    endfunction

    // Residue modulo 7 by folding octal digits, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [11:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[11:9]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

    // A value below 400 is a leap residue when divisible by 4 and not a
    // nonzero multiple of 100.
    function automatic logic leap_res(input logic [8:0] r);
        return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

endpackage

// ===== hdl/iso_week_number.sv =====
// Top level of the ISO 8601 week number pipeline.
// Depends on iwn_pkg, iwn_date_front, iwn_weekday and iwn_week_calc.
//
//   channel   direction   handshake            payload
//   date      in          i_valid / o_stall    i_year, i_month, i_day
//   week      out         o_valid / i_stall    o_iso_week, o_date_error
//
// An accepted item passes the date, year reduction, weekday, division and output registers in order.
// One item can enter every cycle while o_stall is low; each of the five stages holds one item.
// Reset clears all stage valid bits; no result is shown after reset.
// A stalled output holds its item while earlier stages keep filling empty
// slots; o_stall rises only when every stage is occupied.
module iso_week_number (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [iwn_pkg::YEAR_W-1:0]  i_year,
    input  logic [iwn_pkg::MONTH_W-1:0] i_month,
    input  logic [iwn_pkg::DAY_W-1:0]   i_day,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [iwn_pkg::WEEK_W-1:0]  o_iso_week,
    output logic                        o_date_error
);

    logic         front_ready, front_valid;
    iwn_pkg::t_s2 front_data;
    logic         wd_ready, wd_valid;
    iwn_pkg::t_s3 wd_data;
    logic         wc_ready;

    iwn_date_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (front_ready),
        .i_year  (i_year),
        .i_month (i_month),
        .i_day   (i_day),
        .o_valid (front_valid),
        .i_ready (wd_ready),
        .o_data  (front_data)
    );

    iwn_weekday u_weekday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (wd_ready),
        .i_data  (front_data),
        .o_valid (wd_valid),
        .i_ready (wc_ready),
        .o_data  (wd_data)
    );

    iwn_week_calc u_week (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (wd_valid),
        .o_ready (wc_ready),
        .i_data  (wd_data),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_week  (o_iso_week),
        .o_err   (o_date_error)
    );

    assign o_stall = !front_ready;

    a_err_week_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_date_error |-> o_iso_week == '0)
        else $error("invalid date with nonzero week");

    a_week_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_date_error |-> (o_iso_week >= 6'd1) && (o_iso_week <= 6'd53))
        else $error("week number out of range");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall && wd_valid && front_valid)
        else $error("input stalled while the pipeline has a free slot");

endmodule

// ===== hdl/iwn_date_front.sv =====
// Date stages: checks month and day, forms the day of the year and reduces
// the year modulo 400 over two register stages. Depends on iwn_pkg.
module iwn_date_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [iwn_pkg::YEAR_W-1:0]  i_year,
    input  logic [iwn_pkg::MONTH_W-1:0] i_month,
    input  logic [iwn_pkg::DAY_W-1:0]   i_day,
    output logic                        o_valid,
    input  logic                        i_ready,
    output iwn_pkg::t_s2                o_data
);

    logic         r_v1, r_v2;
    iwn_pkg::t_s1 r_s1, n_s1;
    iwn_pkg::t_s2 r_s2, n_s2;
    logic         ready1, ready2;
    logic [21:0]  prod;
    logic [4:0]   mlen;
    logic         mon_ok;
    logic [14:0]  qm;
    logic [14:0]  rem;
    logic [8:0]   r400;
    logic [8:0]   y400;

    assign ready2  = !r_v2 || i_ready;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;

    always_comb begin
        n_s1.p   = 15'(i_year) + iwn_pkg::YEAR_OFFSET;
        prod     = 22'(n_s1.p[14:4]) * 22'(iwn_pkg::RECIP_25);
        n_s1.q_est = prod[21:16];
        mon_ok   = (i_month >= iwn_pkg::JANUARY) && (i_month <= iwn_pkg::DECEMBER);
        mlen     = iwn_pkg::month_len(i_month);
        n_s1.feb29 = (i_month == iwn_pkg::FEBRUARY) && (i_day == 5'd29);
        n_s1.bad_base = !mon_ok || (i_day == 5'd0) || ((i_day > mlen) && !n_s1.feb29);
        n_s1.after_feb = i_month > iwn_pkg::FEBRUARY;
        n_s1.doy_base  = iwn_pkg::days_before(i_month) + 9'(i_day);
    end

    always_comb begin
        qm  = {1'b0, r_s1.q_est, 8'd0} + {2'd0, r_s1.q_est, 7'd0} + {5'd0, r_s1.q_est, 4'd0};
        rem = r_s1.p - qm;
        r400 = (rem >= 15'd400) ? 9'(rem - 15'd400) : rem[8:0];
        y400 = (r400 == 9'd399) ? 9'd0 : r400 + 9'd1;
        n_s2.r400      = r400;
        n_s2.leap      = iwn_pkg::leap_res(y400);
        n_s2.prev_leap = iwn_pkg::leap_res(r400);
        n_s2.err       = r_s1.bad_base || (r_s1.feb29 && !n_s2.leap);
        n_s2.doy       = r_s1.doy_base + 9'(n_s2.leap && r_s1.after_feb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_s1 <= n_s1;
        end
        if (ready2) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_s2;

endmodule

// ===== hdl/iwn_weekday.sv =====
// Weekday stage: ISO weekday of 1 January from the year residue modulo 400.
// Depends on iwn_pkg.
module iwn_weekday (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  iwn_pkg::t_s2 i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output iwn_pkg::t_s3 o_data
);

    logic         r_v;
    iwn_pkg::t_s3 r_s3, n_s3;
    logic         ready;
    logic [8:0]   r100;
    logic [11:0]  sum;
    logic [2:0]   m;

    assign ready   = !r_v || i_ready;
    assign o_ready = ready;

    always_comb begin
        if (i_data.r400 >= 9'd300) begin
            r100 = i_data.r400 - 9'd300;
        end else if (i_data.r400 >= 9'd200) begin
            r100 = i_data.r400 - 9'd200;
        end else if (i_data.r400 >= 9'd100) begin
            r100 = i_data.r400 - 9'd100;
        end else begin
            r100 = i_data.r400;
        end
        // 1 + 5 (p mod 4) + 4 (p mod 100) + 6 (p mod 400), at most 2806.
        sum = 12'd1 + 12'd5 * 12'(i_data.r400[1:0]) + {1'b0, r100, 2'd0}
            + 12'd6 * 12'(i_data.r400);
        m = iwn_pkg::mod7(sum);
        n_s3.j1        = (m == 3'd0) ? iwn_pkg::SUNDAY : m;
        n_s3.leap      = i_data.leap;
        n_s3.prev_leap = i_data.prev_leap;
        n_s3.err       = i_data.err;
        n_s3.doy       = i_data.doy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_s3;

endmodule

// ===== hdl/iwn_week_calc.sv =====
// Week stages: divides the weekday-aligned day count by 7, then settles the
// year-boundary weeks into the output register. Depends on iwn_pkg.
module iwn_week_calc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  iwn_pkg::t_s3               i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [iwn_pkg::WEEK_W-1:0] o_week,
    output logic                       o_err
);

    logic                       r_v4, r_v5;
    logic                       ready4, ready5;
    logic [iwn_pkg::WEEK_W-1:0] r_qw, n_qw;
    iwn_pkg::t_s3               r_s4;
    logic [iwn_pkg::WEEK_W-1:0] r_week, n_week;
    logic                       r_err;
    logic [8:0]                 x;
    logic [17:0]                prod;
    logic [iwn_pkg::WEEK_W-1:0] week0, week1;
    logic [3:0]                 nx;

    assign ready5  = !r_v5 || i_ready;
    assign ready4  = !r_v4 || ready5;
    assign o_ready = ready4;

    always_comb begin
        x    = i_data.doy + 9'(i_data.j1) - 9'd2;
        prod = 18'(x) * 18'(iwn_pkg::RECIP_7);
        n_qw = prod[16:11];
    end

    always_comb begin
        week0 = r_qw + 6'(r_s4.j1 == iwn_pkg::MONDAY);
        week1 = week0 + 6'((r_s4.j1 > iwn_pkg::MONDAY) && (r_s4.j1 <= iwn_pkg::THURSDAY));
        // Weekday of next 1 January: one day later, two after a leap year.
        nx = 4'(r_s4.j1) + 4'd1 + 4'(r_s4.leap);
        if (nx > 4'd7) begin
            nx = nx - 4'd7;
        end
        if (r_s4.err) begin
            n_week = '0;
        end else if ((week0 == 6'd0) && (r_s4.j1 > iwn_pkg::THURSDAY)) begin
            // The date falls in the last week of the previous year.
            if ((r_s4.j1 == iwn_pkg::FRIDAY)
                    || ((r_s4.j1 == iwn_pkg::SATURDAY) && r_s4.prev_leap)) begin
                n_week = iwn_pkg::WEEK_LONG;
            end else begin
                n_week = iwn_pkg::WEEK_SHORT;
            end
        end else if ((week1 == iwn_pkg::WEEK_LONG) && (nx <= 4'(iwn_pkg::THURSDAY))) begin
            n_week = iwn_pkg::WEEK_FIRST;
        end else begin
            n_week = week1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (ready4) begin
                r_v4 <= i_valid;
            end
            if (ready5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready4) begin
            r_qw <= n_qw;
            r_s4 <= i_data;
        end
        if (ready5) begin
            r_week <= n_week;
            r_err  <= r_s4.err;
        end
    end

    assign o_valid = r_v5;
    assign o_week  = r_week;
    assign o_err   = r_err;

    a_weekday_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !r_s4.err |-> r_s4.j1 != 3'd0)
        else $error("weekday of 1 January is zero");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for iso_week_number: dates go in over valid/stall and
// each week result is checked against a behavioral calendar model kept here.
// Depends on iwn_pkg and the iso_week_number RTL.
module testbench;

    localparam int unsigned DAYS_BEFORE [12] = '{0, 31, 59, 90, 120, 151,
                                                 181, 212, 243, 273, 304, 334};
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};
    localparam int unsigned DRAIN_LIMIT = 2000;
    localparam int unsigned DRAIN_SLACK = 8;

    typedef struct {
        int unsigned year;
        int unsigned month;
        int unsigned day;
    } t_cal_date;

    typedef struct {
        t_cal_date                   date;
        logic [iwn_pkg::WEEK_W-1:0]  week;
        logic                        err;
    } t_week_expect;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [iwn_pkg::YEAR_W-1:0]   i_year;
    logic [iwn_pkg::MONTH_W-1:0]  i_month;
    logic [iwn_pkg::DAY_W-1:0]    i_day;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [iwn_pkg::WEEK_W-1:0]   o_iso_week;
    logic                         o_date_error;

    t_week_expect pending_weeks [$];
    int unsigned  mismatches = 0;
    bit           steady = 1'b0;
    int unsigned  hold_request = 0;
    int unsigned  hold_left = 0;

    iso_week_number dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_year       (i_year),
        .i_month      (i_month),
        .i_day        (i_day),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_iso_week   (o_iso_week),
        .o_date_error (o_date_error)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit is_leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        if (m == iwn_pkg::FEBRUARY && is_leap_year(y)) begin
            return 29;
        end
        return MONTH_DAYS[m-1];
    endfunction

    // The first year of every 400-year cycle starts on a Monday. A common year
    // moves the next 1 January on by one weekday, a leap year by two.
    function automatic int unsigned jan1_dow(int unsigned y);
        int unsigned r;
        r = (y + 399) % 400;
        return (r + r / 4 - r / 100) % 7 + 1;
    endfunction

    function automatic t_week_expect predict_week(t_cal_date dt);
        t_week_expect r;
        bit           leap;
        int unsigned  doy;
        int unsigned  dow1;
        int unsigned  wk;
        int unsigned  dow_next;
        r.date = dt;
        r.week = '0;
        r.err  = 1'b1;
        if (dt.month < iwn_pkg::JANUARY || dt.month > iwn_pkg::DECEMBER) begin
            return r;
        end
        if (dt.day < 1 || dt.day > days_in_month(dt.year, dt.month)) begin
            return r;
        end
        r.err = 1'b0;
        leap = is_leap_year(dt.year);
        doy  = DAYS_BEFORE[dt.month-1] + dt.day
             + ((leap && dt.month > iwn_pkg::FEBRUARY) ? 1 : 0);
        dow1 = jan1_dow(dt.year);
        wk   = (doy + dow1 - 2) / 7 + ((dow1 == iwn_pkg::MONDAY) ? 1 : 0);
        if (wk == 0 && dow1 > iwn_pkg::THURSDAY) begin
            // The date sits in the last week of the previous year.
            if (dow1 == iwn_pkg::FRIDAY ||
                (dow1 == iwn_pkg::SATURDAY && dt.year != 0
                 && is_leap_year(dt.year - 1))) begin
                wk = iwn_pkg::WEEK_LONG;
            end else begin
                wk = iwn_pkg::WEEK_SHORT;
            end
        end else begin
            if (dow1 > iwn_pkg::MONDAY && dow1 <= iwn_pkg::THURSDAY) begin
                wk++;
            end
            if (wk == iwn_pkg::WEEK_LONG) begin
                dow_next = (dow1 - 1 + (leap ? 366 : 365)) % 7 + 1;
                if (dow_next <= iwn_pkg::THURSDAY) begin
                    wk = iwn_pkg::WEEK_FIRST;
                end
            end
        end
        r.week = iwn_pkg::WEEK_W'(wk);
        return r;
    endfunction

    function automatic t_cal_date pick_date();
        t_cal_date   dt;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        dt.year = $urandom_range(1601, 9999);
        if (roll < 8) begin
            dt.year  = $urandom_range(0, 16383);
            dt.month = $urandom_range(0, 15);
            dt.day   = $urandom_range(0, 31);
        end else if (roll < 14) begin
            dt.year  = $urandom_range(0, 16383);
            dt.month = $urandom_range(iwn_pkg::JANUARY, iwn_pkg::DECEMBER);
            dt.day   = $urandom_range(1, days_in_month(dt.year, dt.month));
        end else if (roll < 40) begin
            // Turn of the year, where weeks cross from one year to the other.
            if ($urandom_range(0, 1) == 0) begin
                dt.month = iwn_pkg::DECEMBER;
                dt.day   = $urandom_range(22, 31);
            end else begin
                dt.month = iwn_pkg::JANUARY;
                dt.day   = $urandom_range(1, 10);
            end
        end else if (roll < 46) begin
            dt.month = iwn_pkg::FEBRUARY;
            dt.day   = $urandom_range(28, 29);
        end else begin
            dt.month = $urandom_range(iwn_pkg::JANUARY, iwn_pkg::DECEMBER);
            dt.day   = $urandom_range(1, days_in_month(dt.year, dt.month));
        end
        return dt;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // The item is queued for checking when it is first offered; it stays
    // offered until the block takes it, so the order of results is kept.
    task automatic send_date(input t_cal_date dt);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 29) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_year  <= iwn_pkg::YEAR_W'(dt.year);
        i_month <= iwn_pkg::MONTH_W'(dt.month);
        i_day   <= iwn_pkg::DAY_W'(dt.day);
        pending_weeks.push_back(predict_week(dt));
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        int unsigned n;
        n = 0;
        while (pending_weeks.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic test_corner_dates();
        t_cal_date corners [] = '{
            '{0, iwn_pkg::JANUARY, 1}, '{16383, iwn_pkg::DECEMBER, 31},
            '{1601, iwn_pkg::JANUARY, 1}, '{9999, iwn_pkg::DECEMBER, 31},
            '{2020, iwn_pkg::DECEMBER, 31}, '{2021, iwn_pkg::JANUARY, 1},
            '{2021, iwn_pkg::JANUARY, 4}, '{2019, iwn_pkg::DECEMBER, 30},
            '{2016, iwn_pkg::JANUARY, 1}, '{2011, iwn_pkg::JANUARY, 1},
            '{2005, iwn_pkg::JANUARY, 1}, '{2006, iwn_pkg::JANUARY, 1},
            '{2004, iwn_pkg::DECEMBER, 31}, '{2008, iwn_pkg::DECEMBER, 29},
            '{2024, iwn_pkg::FEBRUARY, 29}, '{2023, iwn_pkg::FEBRUARY, 29},
            '{1900, iwn_pkg::FEBRUARY, 29}, '{2000, iwn_pkg::FEBRUARY, 29},
            '{2023, 4, 31}, '{2023, 0, 10}, '{2023, 13, 1}, '{2023, 15, 31},
            '{2023, 6, 0}, '{2023, iwn_pkg::JANUARY, 31}, '{1, iwn_pkg::JANUARY, 1}
        };
        foreach (corners[k]) begin
            send_date(corners[k]);
        end
    endtask

    task automatic test_random_dates(input int unsigned count);
        repeat (count) send_date(pick_date());
    endtask

    // No gaps on either side: one item per cycle in and out.
    task automatic test_full_rate(input int unsigned count);
        steady = 1'b1;
        repeat (count) send_date(pick_date());
        steady = 1'b0;
    endtask

    // The receiver stops taking results while dates keep coming, so every
    // stage fills and the block has to stall its input.
    task automatic test_output_hold(input int unsigned count);
        hold_request = 60;
        steady = 1'b1;
        repeat (count) send_date(pick_date());
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (5) begin
            repeat (10) send_date(pick_date());
            go_quiet();
            wait (pending_weeks.size() == 0);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_request > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_request - 1;
            hold_request = 0;
        end else if (steady) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 29);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_week_expect want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_weeks.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: week %0d error %0b",
                                        o_iso_week, o_date_error));
            end else begin
                want = pending_weeks.pop_front();
                if (o_iso_week !== want.week || o_date_error !== want.err) begin
                    flag_mismatch($sformatf(
                        "%0d-%0d-%0d: expected week %0d error %0b, got week %0d error %0b",
                        want.date.year, want.date.month, want.date.day,
                        want.week, want.err, o_iso_week, o_date_error));
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_year  = '0;
        i_month = '0;
        i_day   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_dates();
        test_random_dates(690);
        test_full_rate(150);
        test_output_hold(40);
        test_drain_pause();
        go_quiet();
        wait_drained();

        if (pending_weeks.size() != 0) begin
            flag_mismatch($sformatf("%0d dates never got a result", pending_weeks.size()));
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
